// ----- rtl/core/tkh_pkg.sv -----
// Shared constants and types for the top-k min-heap selector.
// Used by the compare unit and the top level; depends on nothing.
`default_nettype none

package tkh_pkg;

  localparam int DEF_HEAP_DEPTH = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_COUNT_BITS = 32;

  localparam int          CFG_BITS = 5;
  localparam logic [4:0]  K_RESET  = 5'd16;

  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_A,
    SEL_B
  } sel_t;

endpackage

`default_nettype wire

// ----- rtl/core/tkh_heap_ram.sv -----
// Heap storage: one write port, two read ports with registered read data.
// Standalone; holds key and count of each heap slot packed in one word.
`default_nettype none

module tkh_heap_ram #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 32,
  parameter int AW         = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [KEY_BITS-1:0]   wr_key,
  input  wire logic [COUNT_BITS-1:0] wr_count,
  input  wire logic [AW-1:0]         rd_addr_a,
  input  wire logic [AW-1:0]         rd_addr_b,
  output logic      [KEY_BITS-1:0]   rd_key_a,
  output logic      [COUNT_BITS-1:0] rd_count_a,
  output logic      [KEY_BITS-1:0]   rd_key_b,
  output logic      [COUNT_BITS-1:0] rd_count_b
);

  localparam int WW = KEY_BITS + COUNT_BITS;

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_count, wr_key};
    end
    {rd_count_a, rd_key_a} <= mem[rd_addr_a];
    {rd_count_b, rd_key_b} <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tkh_min_sel.sv -----
// Shared compare unit: picks the smallest of a base count and up to two
// candidates, strict less-than: base wins ties, then A over B. Uses tkh_pkg.
`default_nettype none

module tkh_min_sel #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic [COUNT_BITS-1:0] base,
  input  wire logic [COUNT_BITS-1:0] cand_a,
  input  wire logic                  a_valid,
  input  wire logic [COUNT_BITS-1:0] cand_b,
  input  wire logic                  b_valid,
  output tkh_pkg::sel_t              sel
);
  import tkh_pkg::*;

  logic [COUNT_BITS-1:0] best;
  logic                  take_a;

  always_comb begin
    take_a = a_valid && (cand_a < base);
    best   = take_a ? cand_a : base;
    if (b_valid && (cand_b < best)) begin
      sel = SEL_B;
    end else if (take_a) begin
      sel = SEL_A;
    end else begin
      sel = SEL_BASE;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/top_k_min_heap_select.sv -----
// Top level of the top-k min-heap selector: sequencer, config register, output register.
// Depends on tkh_pkg, tkh_heap_ram and tkh_min_sel.
//
//  channel | direction | handshake           | payload
//  s       | in        | s_tvalid / s_tready | s_tdata = word_key, word_count; s_tlast = last_entry
//  m       | out       | m_tvalid / m_tready | m_tdata = out_key, out_count; m_tlast = out_last
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data = k_in_use
//
// An insert reads the parent and compares it once per level sifted up, writing directly
// when it lands at the root; a replacement reads and compares the root, then reads and
// compares both children once per level sifted down (one heap RAM read and one compare
// per step); a rejected entry stops after the root compare. Each emitted result is read,
// loaded into the output register and held while m_tready is low; s_tready is low until
// the last result is taken. Reset is synchronous; the heap RAM needs no clear.
`default_nettype none

module top_k_min_heap_select #(
  parameter int HEAP_DEPTH = tkh_pkg::DEF_HEAP_DEPTH,
  parameter int KEY_BITS   = tkh_pkg::DEF_KEY_BITS,
  parameter int COUNT_BITS = tkh_pkg::DEF_COUNT_BITS,
  parameter int DATA_W     = ((KEY_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [DATA_W-1:0]             s_tdata,   // word_key, word_count
  input  wire logic                          s_tlast,   // last_entry
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [DATA_W-1:0]             m_tdata,   // out_key, out_count
  output logic                               m_tlast,   // out_last
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tkh_pkg::CFG_BITS-1:0]  cfg_data   // k_in_use
);
  import tkh_pkg::*;

  localparam int AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int FW  = $clog2(HEAP_DEPTH + 1);
  localparam int CW  = $clog2(2 * HEAP_DEPTH + 1);
  localparam int LW  = (FW > CFG_BITS) ? FW : CFG_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

  state_t                state;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         idx;
  logic [FW-1:0]         fill;
  logic [CFG_BITS-1:0]   k_reg;
  logic [KEY_BITS-1:0]   cur_key;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  cur_last;
  logic [KEY_BITS-1:0]   out_key;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_last;
  logic                  out_valid;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_count;
  logic [AW-1:0]         rd_addr_a;
  logic [AW-1:0]         rd_addr_b;
  logic [KEY_BITS-1:0]   rd_key_a;
  logic [COUNT_BITS-1:0] rd_count_a;
  logic [KEY_BITS-1:0]   rd_key_b;
  logic [COUNT_BITS-1:0] rd_count_b;

  logic [COUNT_BITS-1:0] cmp_base;
  logic [COUNT_BITS-1:0] cmp_a;
  logic [COUNT_BITS-1:0] cmp_b;
  logic                  cmp_a_valid;
  logic                  cmp_b_valid;
  sel_t                  cmp_sel;

  logic [LW-1:0]         k_ext;
  logic [LW-1:0]         k_eff;
  logic                  do_insert;
  logic [AW-1:0]         up_idx;
  logic [CW-1:0]         left_idx;
  logic [CW-1:0]         right_idx;
  logic                  left_ok;
  logic                  right_ok;
  logic                  emit_last;
  state_t                done_state;

  tkh_heap_ram #(
    .DEPTH      (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_ram (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_key     (wr_key),
    .wr_count   (wr_count),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .rd_key_a   (rd_key_a),
    .rd_count_a (rd_count_a),
    .rd_key_b   (rd_key_b),
    .rd_count_b (rd_count_b)
  );

  tkh_min_sel #(
    .COUNT_BITS (COUNT_BITS)
  ) u_min_sel (
    .base    (cmp_base),
    .cand_a  (cmp_a),
    .a_valid (cmp_a_valid),
    .cand_b  (cmp_b),
    .b_valid (cmp_b_valid),
    .sel     (cmp_sel)
  );

  always_comb begin
    k_ext = LW'(k_reg);
    if (k_ext == '0) begin
      k_eff = LW'(1);
    end else if (k_ext > LW'(HEAP_DEPTH)) begin
      k_eff = LW'(HEAP_DEPTH);
    end else begin
      k_eff = k_ext;
    end
  end

  assign do_insert  = LW'(fill) < k_eff;
  assign up_idx     = (pos - AW'(1)) >> 1;
  assign left_idx   = (CW'(pos) << 1) + CW'(1);
  assign right_idx  = (CW'(pos) << 1) + CW'(2);
  assign left_ok    = left_idx < CW'(fill);
  assign right_ok   = right_idx < CW'(fill);
  assign emit_last  = (FW'(idx) + FW'(1)) == fill;
  assign done_state = cur_last ? ST_EM_RD : ST_IDLE;

  always_comb begin
    cmp_base    = cur_count;
    cmp_a       = rd_count_a;
    cmp_a_valid = 1'b1;
    cmp_b       = rd_count_b;
    cmp_b_valid = right_ok;
    case (state)
      ST_UP_CMP: begin
        cmp_base    = rd_count_a;
        cmp_a       = cur_count;
        cmp_b_valid = 1'b0;
      end
      ST_ROOT_CMP: begin
        cmp_b_valid = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_key    = cur_key;
    wr_count  = cur_count;
    rd_addr_a = left_idx[AW-1:0];
    rd_addr_b = right_idx[AW-1:0];
    case (state)
      ST_UP_RD: begin
        rd_addr_a = up_idx;
        wr_en     = (pos == '0);
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_sel == SEL_A) begin
          wr_key   = rd_key_a;
          wr_count = rd_count_a;
        end
      end
      ST_ROOT_RD: begin
        rd_addr_a = '0;
      end
      ST_DN_RD: begin
        wr_en = !left_ok;
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_sel == SEL_A) begin
          wr_key   = rd_key_a;
          wr_count = rd_count_a;
        end else if (cmp_sel == SEL_B) begin
          wr_key   = rd_key_b;
          wr_count = rd_count_b;
        end
      end
      ST_EM_RD: begin
        rd_addr_a = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      idx       <= '0;
      pos       <= '0;
      k_reg     <= K_RESET;
      out_valid <= 1'b0;
      cur_last  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        k_reg <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_key   <= s_tdata[KEY_BITS-1:0];
            cur_count <= s_tdata[KEY_BITS +: COUNT_BITS];
            cur_last  <= s_tlast;
            idx       <= '0;
            if (do_insert) begin
              pos   <= fill[AW-1:0];
              fill  <= fill + FW'(1);
              state <= ST_UP_RD;
            end else begin
              state <= ST_ROOT_RD;
            end
          end
        end
        ST_UP_RD: begin
          state <= (pos == '0) ? done_state : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (cmp_sel == SEL_A) begin
            pos   <= up_idx;
            state <= ST_UP_RD;
          end else begin
            state <= done_state;
          end
        end
        ST_ROOT_RD: begin
          state <= ST_ROOT_CMP;
        end
        ST_ROOT_CMP: begin
          if (cmp_sel == SEL_A) begin
            pos   <= '0;
            state <= ST_DN_RD;
          end else begin
            state <= done_state;
          end
        end
        ST_DN_RD: begin
          state <= left_ok ? ST_DN_CMP : done_state;
        end
        ST_DN_CMP: begin
          if (cmp_sel == SEL_A) begin
            pos   <= left_idx[AW-1:0];
            state <= ST_DN_RD;
          end else if (cmp_sel == SEL_B) begin
            pos   <= right_idx[AW-1:0];
            state <= ST_DN_RD;
          end else begin
            state <= done_state;
          end
        end
        ST_EM_RD: begin
          state <= ST_EM_LD;
        end
        ST_EM_LD: begin
          out_key   <= rd_key_a;
          out_count <= rd_count_a;
          out_last  <= emit_last;
          out_valid <= 1'b1;
          state     <= ST_EM_WAIT;
        end
        ST_EM_WAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              fill  <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_EM_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tlast   = out_last;
  assign m_tdata   = DATA_W'({out_count, out_key});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(HEAP_DEPTH))
    else $error("heap fill beyond depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (fill == '0 && s_tready))
    else $error("heap not emptied after final result");

  a_pos_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RD || state == ST_DN_CMP || state == ST_UP_CMP) |-> (FW'(pos) < fill))
    else $error("sift position outside held entries");

endmodule

`default_nettype wire
